// ===== sv/atfb_pkg.sv =====
// Shared types and constants of the transmit-request frame builder.
`default_nettype none

package atfb_pkg;

    localparam logic [7:0] MaxPayload  = 8'd254;
    localparam logic [8:0] HeaderExtra = 9'd15;
    localparam logic [7:0] StartDelim  = 8'h7E;
    localparam logic [7:0] FrameType   = 8'h10;

    // Byte positions inside the header burst of a start transaction.
    localparam logic [4:0] HdrLenHiIdx   = 5'd1;
    localparam logic [4:0] HdrLenLoIdx   = 5'd2;
    localparam logic [4:0] HdrTypeIdx    = 5'd3;
    localparam logic [4:0] HdrIdentIdx   = 5'd4;
    localparam logic [4:0] HdrDest64Last = 5'd12;
    localparam logic [4:0] HdrDest16Hi   = 5'd13;
    localparam logic [4:0] HdrDest16Lo   = 5'd14;
    localparam logic [4:0] HdrRadiusIdx  = 5'd15;
    localparam logic [4:0] HdrOptionsIdx = 5'd16;
    localparam logic [4:0] HdrPacketIdx  = 5'd17;
    localparam logic [4:0] HdrCheckIdx   = 5'd18;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueueAw    = $clog2(QueueDepth);

    localparam logic [63:0] Dest64Reset  = 64'h0013_A200_4060_F498;
    localparam logic [15:0] Dest16Reset  = 16'hFFFE;
    localparam logic [7:0]  IdentReset   = 8'h01;
    localparam logic [7:0]  RadiusReset  = 8'h00;
    localparam logic [7:0]  OptionsReset = 8'h00;

    localparam int unsigned PaddrW = 6;
    localparam int unsigned PdataW = 64;

    typedef enum logic [2:0] {
        REG_DEST64  = 3'd0,
        REG_DEST16  = 3'd1,
        REG_IDENT   = 3'd2,
        REG_RADIUS  = 3'd3,
        REG_OPTIONS = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_ERR   = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] len;
        logic [7:0] data;
        logic       close;
    } t_cmd;

    typedef struct packed {
        logic [63:0] dest64;
        logic [15:0] dest16;
        logic [7:0]  ident;
        logic [7:0]  radius;
        logic [7:0]  options;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/atfb_if.sv =====
// Valid/ready channel interfaces for the command input and the byte output.
`default_nettype none

interface atfb_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] payload_len;
    logic [7:0] packet_id;
    logic [7:0] payload_byte;

    modport source (output valid, cmd, payload_len, packet_id, payload_byte, input ready);
    modport sink   (input valid, cmd, payload_len, packet_id, payload_byte, output ready);
endinterface

interface atfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_in_run;
    logic       frame_end;
    logic       sequence_error;

    modport source (output valid, tx_byte, last_in_run, frame_end, sequence_error,
                    input ready);
    modport sink   (input valid, tx_byte, last_in_run, frame_end, sequence_error,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/atfb_cfg.sv =====
// APB register block holding the header configuration.
`default_nettype none

module atfb_cfg
    import atfb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [PaddrW-1:0] paddr,
    input  wire logic [PdataW-1:0] pwdata,
    output logic      [PdataW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[PaddrW-1:3]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_DEST64:  n_cfg.dest64  = pwdata;
                REG_DEST16:  n_cfg.dest16  = pwdata[15:0];
                REG_IDENT:   n_cfg.ident   = pwdata[7:0];
                REG_RADIUS:  n_cfg.radius  = pwdata[7:0];
                REG_OPTIONS: n_cfg.options = pwdata[7:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEST64:  prdata = r_cfg.dest64;
            REG_DEST16:  prdata = {48'd0, r_cfg.dest16};
            REG_IDENT:   prdata = {56'd0, r_cfg.ident};
            REG_RADIUS:  prdata = {56'd0, r_cfg.radius};
            REG_OPTIONS: prdata = {56'd0, r_cfg.options};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest64  <= Dest64Reset;
            r_cfg.dest16  <= Dest16Reset;
            r_cfg.ident   <= IdentReset;
            r_cfg.radius  <= RadiusReset;
            r_cfg.options <= OptionsReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/atfb_front.sv =====
// Front end: accepts commands, tracks frame state and classifies each transaction.
`default_nettype none

module atfb_front
    import atfb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    atfb_in_if.sink   i_req,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic       r_open;
    logic       n_open;
    logic [7:0] r_remaining;
    logic [7:0] n_remaining;
    logic [7:0] len_sat;
    logic       accept;

    assign i_req.ready = !i_q_full;
    assign accept      = i_req.valid && i_req.ready;
    assign o_push      = accept;
    assign len_sat     = (i_req.payload_len > MaxPayload) ? MaxPayload : i_req.payload_len;

    always_comb begin
        n_open      = r_open;
        n_remaining = r_remaining;
        o_cmd.len   = len_sat;
        priority if (!i_req.cmd) begin
            o_cmd.op    = OP_START;
            o_cmd.data  = i_req.packet_id;
            o_cmd.close = (len_sat == 8'd0);
            if (accept) begin
                n_open      = (len_sat != 8'd0);
                n_remaining = len_sat;
            end
        end else if (r_open) begin
            o_cmd.op    = OP_DATA;
            o_cmd.data  = i_req.payload_byte;
            o_cmd.close = (r_remaining == 8'd1);
            if (accept) begin
                n_open      = (r_remaining != 8'd1);
                n_remaining = r_remaining - 8'd1;
            end
        end else begin
            o_cmd.op    = OP_ERR;
            o_cmd.data  = 8'd0;
            o_cmd.close = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= 8'd0;
        end else begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
        end
    end

endmodule

`default_nettype wire

// ===== sv/atfb_queue.sv =====
// Short command queue between the front end and the byte sequencer.
`default_nettype none

module atfb_queue
    import atfb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty
);

    t_cmd               r_mem [QueueDepth];
    logic [QueueAw-1:0] r_wr_ptr;
    logic [QueueAw-1:0] r_rd_ptr;
    logic [QueueAw:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == (QueueAw+1)'(QueueDepth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/atfb_back.sv =====
// Back end: expands queued commands into frame bytes and keeps the checksum.
`default_nettype none

module atfb_back
    import atfb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire t_cmd i_cmd,
    input  wire logic i_empty,
    output logic      o_pop,
    atfb_out_if.source o_rsp
);

    logic [4:0] r_idx;
    logic [4:0] n_idx;
    logic [7:0] r_sum;
    logic [7:0] n_sum;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_end;
    logic       r_err;

    logic       step;
    logic [7:0] hdr_byte;
    logic [8:0] total;
    logic [2:0] dest_k;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_end;
    logic       out_err;
    logic       add_sum;
    logic [7:0] sum_base;

    assign step   = !i_empty && (!r_valid || o_rsp.ready);
    assign total  = {1'b0, i_cmd.len} + HeaderExtra;
    assign dest_k = 3'(HdrDest64Last - r_idx);

    always_comb begin
        priority if (r_idx == 5'd0) begin
            hdr_byte = StartDelim;
        end else if (r_idx == HdrLenHiIdx) begin
            hdr_byte = {7'd0, total[8]};
        end else if (r_idx == HdrLenLoIdx) begin
            hdr_byte = total[7:0];
        end else if (r_idx == HdrTypeIdx) begin
            hdr_byte = FrameType;
        end else if (r_idx == HdrIdentIdx) begin
            hdr_byte = i_cfg.ident;
        end else if (r_idx <= HdrDest64Last) begin
            hdr_byte = 8'(i_cfg.dest64 >> {dest_k, 3'b000});
        end else if (r_idx == HdrDest16Hi) begin
            hdr_byte = i_cfg.dest16[15:8];
        end else if (r_idx == HdrDest16Lo) begin
            hdr_byte = i_cfg.dest16[7:0];
        end else if (r_idx == HdrRadiusIdx) begin
            hdr_byte = i_cfg.radius;
        end else if (r_idx == HdrOptionsIdx) begin
            hdr_byte = i_cfg.options;
        end else begin
            hdr_byte = i_cmd.data;
        end
    end

    always_comb begin
        out_byte = 8'd0;
        out_last = 1'b0;
        out_end  = 1'b0;
        out_err  = 1'b0;
        add_sum  = 1'b0;
        // A start restarts the sum, which also drops an abandoned frame.
        sum_base = (i_cmd.op == OP_START && r_idx == 5'd0) ? 8'd0 : r_sum;
        case (i_cmd.op)
            OP_START: begin
                if (r_idx == HdrCheckIdx) begin
                    out_byte = ~r_sum;
                    out_end  = 1'b1;
                    out_last = 1'b1;
                end else begin
                    out_byte = hdr_byte;
                    add_sum  = (r_idx >= HdrTypeIdx);
                    out_last = (r_idx == HdrPacketIdx) && !i_cmd.close;
                end
            end
            OP_DATA: begin
                if (r_idx == 5'd0) begin
                    out_byte = i_cmd.data;
                    add_sum  = 1'b1;
                    out_last = !i_cmd.close;
                end else begin
                    out_byte = ~r_sum;
                    out_end  = 1'b1;
                    out_last = 1'b1;
                end
            end
            default: begin
                out_err  = 1'b1;
                out_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        n_sum = r_sum;
        if (step) begin
            n_idx = out_last ? 5'd0 : r_idx + 5'd1;
            if (out_end) begin
                n_sum = 8'd0;
            end else if (add_sum) begin
                n_sum = sum_base + out_byte;
            end else begin
                n_sum = sum_base;
            end
        end
    end

    assign o_pop = step && out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 5'd0;
            r_sum   <= 8'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_sum <= n_sum;
            if (step) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte <= out_byte;
            r_last <= out_last;
            r_end  <= out_end;
            r_err  <= out_err;
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.tx_byte        = r_byte;
    assign o_rsp.last_in_run    = r_last;
    assign o_rsp.frame_end      = r_end;
    assign o_rsp.sequence_error = r_err;

endmodule

`default_nettype wire

// ===== sv/api_transmit_frame_builder_core.sv =====
// Top level of the transmit-request frame builder.
// Commands are queued, bytes registered at the output. Throughput: one output byte per cycle
// while o_rsp is ready, set by the byte sequencer; a start yields 18 or 19 bytes, a payload
// byte 1 or 2; payload bytes are accepted one per cycle while the queue is not full.
// Reset: synchronous active low; clears frame state, queue, sum and restores register defaults.
`default_nettype none

module api_transmit_frame_builder_core
    import atfb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    atfb_in_if.sink                i_req,
    atfb_out_if.source             o_rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [PaddrW-1:0] paddr,
    input  wire logic [PdataW-1:0] pwdata,
    output logic      [PdataW-1:0] prdata,
    output logic                   pready
);

    t_cfg cfg;
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    atfb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    atfb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    atfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty)
    );

    atfb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (head_cmd),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

    a_err_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.sequence_error |-> o_rsp.last_in_run && !o_rsp.frame_end)
        else $error("sequence error result is not a single closing result");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.frame_end |-> o_rsp.last_in_run)
        else $error("checksum byte not marked last in run");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("sequencer retired a command from an empty queue");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_rsp.valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
